[sv/prdt_pkg.sv]
// ----------------------------------------------------------------------------
// prdt_pkg
// shared types and constants of the palette memory with dirty tracking
// ----------------------------------------------------------------------------
package prdt_pkg;

  localparam int ADDR_W = 10;
  localparam int DATA_W = 32;
  localparam int HALF_W = 16;
  localparam int ROW_W  = 8;
  localparam int ROWS   = 1 << ROW_W;

  // access codes
  localparam logic       OP_LOAD    = 1'b0;
  localparam logic       OP_STORE   = 1'b1;
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_HALF  = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_NONE  = 2'd3;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [DATA_W-1:0] word_t;

  // one row holds two halfwords: low at the word-aligned address, high above it
  typedef struct packed {
    logic  en;
    row_t  row;
    word_t data;
  } mem_wr_t;

  typedef struct packed {
    logic              op;
    logic [1:0]        size;
    logic [ADDR_W-1:0] addr;
    word_t             wdata;
  } req_t;

endpackage

[sv/palette_ram_with_dirty_tracking.sv]
// ----------------------------------------------------------------------------
// palette_ram_with_dirty_tracking
// 1 KiB palette memory, byte/halfword/word access, sticky dirty flags
// ----------------------------------------------------------------------------
// path: request and row read are registered, then the result register drives the strobe
// throughput: one access per cycle outside reset, each a single row read-modify-write
// reset: busy while in reset and until the busy register clears after release; flags and row valid bits cleared
// memory reads as zero until written; results cannot be stalled by the receiver
module palette_ram_with_dirty_tracking (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [1:0]                    in_access_size,
  input  logic [prdt_pkg::ADDR_W-1:0]   in_address,
  input  logic [prdt_pkg::DATA_W-1:0]   in_write_data,
  output logic                          out_valid,
  output logic [prdt_pkg::DATA_W-1:0]   out_read_data,
  output logic                          out_dirty_background,
  output logic                          out_dirty_object
);
  import prdt_pkg::*;

  logic    busy_r;
  logic    accept;
  req_t    req;
  word_t   row_data;
  mem_wr_t wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;
  assign req    = '{op: in_operation, size: in_access_size, addr: in_address,
                    wdata: in_write_data};

  prdt_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_row  (in_address[ADDR_W-1:2]),
    .wr      (wr),
    .rd_data (row_data)
  );

  prdt_exec u_exec (
    .clk                  (clk),
    .rst_n                (rst_n),
    .accept               (accept),
    .req                  (req),
    .row_data             (row_data),
    .wr                   (wr),
    .out_valid            (out_valid),
    .out_read_data        (out_read_data),
    .out_dirty_background (out_dirty_background),
    .out_dirty_object     (out_dirty_object)
  );

endmodule

[sv/prdt_mem.sv]
// ----------------------------------------------------------------------------
// prdt_mem
// 256 x 32 palette row store with per-row valid bits and write forwarding
// ----------------------------------------------------------------------------
module prdt_mem (
  input  logic            clk,
  input  logic            rst_n,
  input  prdt_pkg::row_t  rd_row,
  input  prdt_pkg::mem_wr_t wr,
  output prdt_pkg::word_t rd_data
);
  import prdt_pkg::*;

  word_t            mem [ROWS];
  logic [ROWS-1:0]  valid_r;
  word_t            raw_r;
  logic             hit_r;
  logic             byp_r;
  word_t            byp_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.data;
    end
    raw_r      <= mem[rd_row];
    byp_data_r <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
      byp_r   <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.row] <= 1'b1;
      end
      hit_r <= valid_r[rd_row];
      byp_r <= wr.en && (wr.row == rd_row);
    end
  end

  // unwritten rows read as zero
  assign rd_data = byp_r ? byp_data_r : (hit_r ? raw_r : '0);

endmodule

[sv/prdt_exec.sv]
// ----------------------------------------------------------------------------
// prdt_exec
// request register, load select, store merge, dirty flags and result register
// ----------------------------------------------------------------------------
module prdt_exec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  prdt_pkg::req_t    req,
  input  prdt_pkg::word_t   row_data,
  output prdt_pkg::mem_wr_t wr,
  output logic              out_valid,
  output prdt_pkg::word_t   out_read_data,
  output logic              out_dirty_background,
  output logic              out_dirty_object
);
  import prdt_pkg::*;

  logic             req_vld_r;
  req_t             req_r;
  logic [1:0]       dirty_r;
  logic [1:0]       dirty_nxt;
  logic             out_valid_r;
  word_t            out_data_r;
  word_t            out_data_nxt;
  logic [HALF_W-1:0] lo;
  logic [HALF_W-1:0] hi;
  logic [HALF_W-1:0] sel_half;
  logic [HALF_W-1:0] dup_byte;
  word_t            new_row;
  logic             size_ok;

  always_ff @(posedge clk) begin
    req_r <= req;
  end

  always_comb begin
    lo       = row_data[HALF_W-1:0];
    hi       = row_data[DATA_W-1:HALF_W];
    sel_half = req_r.addr[1] ? hi : lo;
    dup_byte = {req_r.wdata[7:0], req_r.wdata[7:0]};
    new_row  = row_data;
    size_ok  = 1'b1;
    out_data_nxt = '0;
    case (req_r.size)
      SIZE_BYTE: begin
        out_data_nxt = {24'd0, req_r.addr[0] ? sel_half[15:8] : sel_half[7:0]};
        if (req_r.addr[1]) begin
          new_row = {dup_byte, lo};
        end else begin
          new_row = {hi, dup_byte};
        end
      end
      SIZE_HALF: begin
        out_data_nxt = {16'd0, sel_half};
        if (req_r.addr[1]) begin
          new_row = {req_r.wdata[HALF_W-1:0], lo};
        end else begin
          new_row = {hi, req_r.wdata[HALF_W-1:0]};
        end
      end
      SIZE_WORD: begin
        out_data_nxt = row_data;
        new_row      = req_r.wdata;
      end
      default: begin
        size_ok = 1'b0;
      end
    endcase
    if (req_r.op == OP_STORE) begin
      out_data_nxt = '0;
    end

    wr.en   = req_vld_r && (req_r.op == OP_STORE) && size_ok;
    wr.row  = req_r.addr[ADDR_W-1:2];
    wr.data = new_row;

    dirty_nxt = dirty_r;
    if (wr.en && (new_row != row_data)) begin
      dirty_nxt[req_r.addr[ADDR_W-1]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r   <= 1'b0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      req_vld_r   <= accept;
      dirty_r     <= dirty_nxt;
      out_valid_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_read_data        = out_data_r;
  assign out_dirty_background = dirty_r[0];
  assign out_dirty_object     = dirty_r[1];

endmodule

[sv/prdt_checker.sv]
// ----------------------------------------------------------------------------
// prdt_checker
// port-level checks of result timing, store results, sticky flags and busy
// ----------------------------------------------------------------------------
module prdt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_operation,
  input logic [1:0]                  in_access_size,
  input logic                        out_valid,
  input logic [prdt_pkg::DATA_W-1:0] out_read_data,
  input logic                        out_dirty_background,
  input logic                        out_dirty_object
);
  import prdt_pkg::*;

  logic acc;
  assign acc = start && !busy;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc ##1 rst_n |=> out_valid)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> ##1 !out_valid)
    else $error("result without an accepted word");

  a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_operation == OP_STORE || in_access_size == SIZE_NONE)) |=> ##1
      (!out_valid || out_read_data == '0))
    else $error("store or empty access returned nonzero data");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(rst_n) &&
    (($past(out_dirty_background) && !out_dirty_background) ||
     ($past(out_dirty_object) && !out_dirty_object)) |-> 1'b0)
    else $error("dirty flag cleared outside reset");

  a_busy_only_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset");

endmodule

bind palette_ram_with_dirty_tracking prdt_checker u_prdt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .in_operation         (in_operation),
  .in_access_size       (in_access_size),
  .out_valid            (out_valid),
  .out_read_data        (out_read_data),
  .out_dirty_background (out_dirty_background),
  .out_dirty_object     (out_dirty_object)
);
